### hdl/silu_pkg.sv
// shared types and constants of the sorted insertion list
package silu_pkg;

  localparam int unsigned KEY_W     = 32;
  localparam int unsigned DEPTH_DEF = 16;

  // action codes of an input beat
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DUMP   = 1'b1;

  // broadcast control seen by every cell
  typedef struct packed {
    logic             ins;   // place key at its sorted position
    logic             rot;   // rotate occupied cells one step toward cell 0
    logic [KEY_W-1:0] key;   // key being inserted
    logic [KEY_W-1:0] wrap;  // key of cell 0, closes the ring on rotate
  } cell_ctrl_t;

endpackage

### hdl/silu_cell.sv
// one compare-and-shift cell of the sorted key chain
module silu_cell
  import silu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic [KEY_W-1:0] left_key_i,
  input  logic             left_occ_i,
  input  logic             left_gt_i,
  input  logic [KEY_W-1:0] right_key_i,
  input  logic             right_occ_i,
  output logic [KEY_W-1:0] key_o,
  output logic             occ_o,
  output logic             gt_o
);

  logic [KEY_W-1:0] key_q, key_d;
  logic             occ_q, occ_d;

  assign gt_o  = occ_q && ($signed(key_q) > $signed(ctrl_i.key));
  assign key_o = key_q;
  assign occ_o = occ_q;

  always_comb begin
    key_d = key_q;
    occ_d = occ_q;
    if (ctrl_i.ins) begin
      if (gt_o) begin
        key_d = left_gt_i ? left_key_i : ctrl_i.key;
      end else if (!occ_q && left_occ_i) begin
        // first free cell takes the key or the one pushed up from the left
        key_d = left_gt_i ? left_key_i : ctrl_i.key;
        occ_d = 1'b1;
      end
    end else if (ctrl_i.rot && occ_q) begin
      key_d = right_occ_i ? right_key_i : ctrl_i.wrap;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

### hdl/sorted_insertion_list_unit.sv
// top level of the sorted insertion list: cell chain, dump sequencer, output register
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------------------
//   in      | input     | in_valid_i / in_ready_o | action_i, key_in_i
//   out     | output    | out_valid_o/out_ready_i | key_out_o, valid_res_o, last_o, overflowed_o
//
// an insert beat never holds the input: every cell compares against the broadcast key
// and shifts in parallel, so inserts may follow back to back
// a dump beat holds the input until its last key is loaded (one beat for an empty store), one key
// per cycle while the output has room, as the chain rotates toward cell 0; after one rotation per
// stored key the store is back as it was; output stalls simply pause the rotation, nothing is lost
// reset clears occupancy, count, overflow flag and the output valid; keys need none
module sorted_insertion_list_unit
  import silu_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             action_i,
  input  logic [KEY_W-1:0] key_in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [KEY_W-1:0] key_out_o,
  output logic             valid_res_o,
  output logic             last_o,
  output logic             overflowed_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  // chain wiring
  logic [KEY_W-1:0] key_w [DEPTH];
  logic [DEPTH-1:0] occ_w;
  logic [DEPTH-1:0] gt_w;
  cell_ctrl_t       ctrl;

  // control state
  logic          dump_q, dump_d;
  logic [CW-1:0] cnt_q, cnt_d;   // number of stored keys
  logic [CW-1:0] idx_q, idx_d;   // beats emitted in the running dump
  logic          ovf_q, ovf_d;

  // output register
  logic             ovld_q, ovld_d;
  logic [KEY_W-1:0] okey_q, okey_d;
  logic             ores_q, ores_d;
  logic             olast_q, olast_d;
  logic             oovf_q, oovf_d;

  logic in_fire, ins_fire, out_free, beat_load, full, last_beat;

  assign in_ready_o = !dump_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign ins_fire   = in_fire && (action_i == ACT_INSERT);
  assign full       = occ_w[DEPTH-1];
  assign out_free   = !ovld_q || out_ready_i;
  assign beat_load  = dump_q && out_free;
  assign last_beat  = (cnt_q == '0) || (idx_q == cnt_q - CW'(1));

  assign ctrl.ins  = ins_fire;
  assign ctrl.rot  = beat_load && (cnt_q != '0);
  assign ctrl.key  = key_in_i;
  assign ctrl.wrap = key_w[0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] lkey, rkey;
    logic             locc, lgt, rocc;
    if (i == 0) begin : g_head
      // the head cell sees an occupied neighbor that is never greater
      assign lkey = '0;
      assign locc = 1'b1;
      assign lgt  = 1'b0;
    end else begin : g_body
      assign lkey = key_w[i-1];
      assign locc = occ_w[i-1];
      assign lgt  = gt_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign rkey = '0;
      assign rocc = 1'b0;
    end else begin : g_mid
      assign rkey = key_w[i+1];
      assign rocc = occ_w[i+1];
    end
    silu_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .left_key_i  (lkey),
      .left_occ_i  (locc),
      .left_gt_i   (lgt),
      .right_key_i (rkey),
      .right_occ_i (rocc),
      .key_o       (key_w[i]),
      .occ_o       (occ_w[i]),
      .gt_o        (gt_w[i])
    );
  end

  always_comb begin
    dump_d = dump_q;
    cnt_d  = cnt_q;
    idx_d  = idx_q;
    ovf_d  = ovf_q;
    if (ins_fire) begin
      // a full store drops its largest candidate and keeps its count
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CW'(1);
      end
    end
    if (in_fire && (action_i == ACT_DUMP)) begin
      dump_d = 1'b1;
      idx_d  = '0;
    end
    if (beat_load) begin
      idx_d = idx_q + CW'(1);
      if (last_beat) begin
        dump_d = 1'b0;
      end
    end
  end

  always_comb begin
    ovld_d  = ovld_q;
    okey_d  = okey_q;
    ores_d  = ores_q;
    olast_d = olast_q;
    oovf_d  = oovf_q;
    if (beat_load) begin
      ovld_d  = 1'b1;
      okey_d  = (cnt_q == '0) ? '0 : key_w[0];
      ores_d  = (cnt_q != '0);
      olast_d = last_beat;
      oovf_d  = ovf_q;
    end else if (out_ready_i) begin
      ovld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dump_q <= 1'b0;
      cnt_q  <= '0;
      idx_q  <= '0;
      ovf_q  <= 1'b0;
      ovld_q <= 1'b0;
    end else begin
      dump_q <= dump_d;
      cnt_q  <= cnt_d;
      idx_q  <= idx_d;
      ovf_q  <= ovf_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    okey_q  <= okey_d;
    ores_q  <= ores_d;
    olast_q <= olast_d;
    oovf_q  <= oovf_d;
  end

  assign out_valid_o  = ovld_q;
  assign key_out_o    = okey_q;
  assign valid_res_o  = ores_q;
  assign last_o       = olast_q;
  assign overflowed_o = oovf_q;

  // occupied cells always form a prefix of the chain
  a_occ_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_w & (occ_w + DEPTH'(1))) == '0)
    else $error("occupied cells are not a prefix");

  // the count tracks the occupied cells
  a_cnt_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(occ_w) == int'(cnt_q))
    else $error("key count disagrees with occupancy");

  // a running dump never walks past the stored keys
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dump_q |-> (idx_q < cnt_q || (cnt_q == '0 && idx_q == '0)))
    else $error("dump index out of range");

  // the overflow flag is sticky
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q)
    else $error("overflow flag cleared");

endmodule

### tb/silu_checker.sv
// checker for the sorted insertion list: tracks the stored keys and checks every dump beat
module silu_checker
  import silu_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic             action_i,
  input  logic [KEY_W-1:0] key_in_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [KEY_W-1:0] key_out_i,
  input  logic             valid_res_i,
  input  logic             last_i,
  input  logic             overflowed_i,
  output int               fail_cnt_o,
  output int               pending_o,
  output int               beats_checked_o
);

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             valid_res;
    logic             last;
    logic             overflowed;
  } dump_beat_t;

  logic signed [KEY_W-1:0] sorted_q[$];
  dump_beat_t              dump_q[$];
  logic                    overflow_seen = 1'b0;
  int                      fails         = 0;
  int                      checked       = 0;

  // full store: the largest of the stored keys plus the new one is lost
  function automatic void place_key(input logic signed [KEY_W-1:0] k);
    int pos;
    if (sorted_q.size() >= DEPTH) begin
      overflow_seen = 1'b1;
      if (k >= sorted_q[DEPTH-1]) return;
      void'(sorted_q.pop_back());
    end
    pos = sorted_q.size();
    while (pos > 0 && sorted_q[pos-1] > k) pos--;
    sorted_q.insert(pos, k);
  endfunction

  function automatic void queue_dump();
    dump_beat_t b;
    int         n;
    n = sorted_q.size();
    b.overflowed = overflow_seen;
    if (n == 0) begin
      b.key       = '0;
      b.valid_res = 1'b0;
      b.last      = 1'b1;
      dump_q.push_back(b);
    end else begin
      for (int i = 0; i < n; i++) begin
        b.key       = sorted_q[i];
        b.valid_res = 1'b1;
        b.last      = (i == n - 1);
        dump_q.push_back(b);
      end
    end
  endfunction

  always @(posedge clk_i) begin : track
    dump_beat_t want;
    if (!rst_ni) begin
      sorted_q.delete();
      dump_q.delete();
      overflow_seen = 1'b0;
    end else begin
      // each input beat is predicted at the edge that accepts it
      if (in_valid_i && in_ready_i) begin
        if (action_i == ACT_INSERT) place_key(key_in_i);
        else queue_dump();
      end

      if (out_valid_i && out_ready_i) begin
        if (dump_q.size() == 0) begin
          $error("result beat with no dump pending: key_out %0d", $signed(key_out_i));
          fails++;
        end else begin
          want = dump_q.pop_front();
          checked++;
          if (key_out_i !== want.key) begin
            $error("key_out mismatch: expected %0d, got %0d",
                   $signed(want.key), $signed(key_out_i));
            fails++;
          end
          if (valid_res_i !== want.valid_res) begin
            $error("valid_res mismatch: expected %0b, got %0b", want.valid_res, valid_res_i);
            fails++;
          end
          if (last_i !== want.last) begin
            $error("last mismatch: expected %0b, got %0b", want.last, last_i);
            fails++;
          end
          if (overflowed_i !== want.overflowed) begin
            $error("overflowed mismatch: expected %0b, got %0b",
                   want.overflowed, overflowed_i);
            fails++;
          end
        end
      end
    end
    fail_cnt_o      <= fails;
    pending_o       <= dump_q.size();
    beats_checked_o <= checked;
  end

endmodule

### tb/testbench.sv
// top of the sorted insertion list testbench: clock, reset, stimulus, watchdog and verdict
module testbench
  import silu_pkg::*;
();

  localparam int unsigned DEPTH        = DEPTH_DEF;
  localparam int          RANDOM_ITEMS = 90;   // random beats after the directed part
  localparam int          CALM_ITEMS   = 20;   // tail of the run without any idling
  localparam int          STALL_AT     = 35;   // random beat where the long hold starts
  localparam int          LONG_HOLD    = 64;   // receiver hold-off, longer than a full dump
  localparam int          DRAIN_CYCLES = 20;   // quiet time after the last expected beat
  localparam int          STUCK_LIMIT  = 1000; // cycles without any beat before giving up

  localparam logic [KEY_W-1:0] MIN_KEY = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic [KEY_W-1:0] MAX_KEY = {1'b0, {(KEY_W-1){1'b1}}};

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             action_i;
  logic [KEY_W-1:0] key_in_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [KEY_W-1:0] key_out_o;
  logic             valid_res_o;
  logic             last_o;
  logic             overflowed_o;

  int   fails;
  int   pending;
  int   beats_checked;
  int   n_inserts  = 0;
  int   n_dumps    = 0;
  logic calm       = 1'b0;  // set for the last part of the run: no idling on either side
  logic stall_req  = 1'b0;  // asks the receiver for its one long hold-off

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  sorted_insertion_list_unit #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .key_in_i    (key_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .key_out_o   (key_out_o),
    .valid_res_o (valid_res_o),
    .last_o      (last_o),
    .overflowed_o(overflowed_o)
  );

  // watches both channels, keeps its own sorted store and compares every result beat
  silu_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .action_i       (action_i),
    .key_in_i       (key_in_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .key_out_i      (key_out_o),
    .valid_res_i    (valid_res_o),
    .last_i         (last_o),
    .overflowed_i   (overflowed_o),
    .fail_cnt_o     (fails),
    .pending_o      (pending),
    .beats_checked_o(beats_checked)
  );

  // keys come in flavors: anything at all, a narrow band around zero so that
  // duplicates show up, the two extremes, and a band just above the minimum
  // that keeps displacing the largest key once the store is full
  function automatic logic [KEY_W-1:0] pick_key();
    int k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: k = $urandom;
      4, 5, 6:    k = int'($urandom_range(0, 40)) - 20;
      7:          k = $urandom_range(0, 1) ? MAX_KEY : MIN_KEY;
      default:    k = MIN_KEY + $urandom_range(0, 1000);
    endcase
    return k;
  endfunction

  // offers one beat, sometimes after a random gap, and holds it until taken
  task automatic send_beat(input logic act, input logic [KEY_W-1:0] k);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    key_in_i   <= k;
    do @(posedge clk_i); while (!in_ready_o);
    if (act == ACT_DUMP) n_dumps++;
    else n_inserts++;
  endtask

  // receiver: random back-pressure bursts plus one long hold-off on request
  initial begin : receiver
    bit stall_done;
    stall_done = 1'b0;
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (stall_req && !stall_done) begin
        // long enough for a full-store dump to back up into the input channel
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        stall_done = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  // watchdog: any cycle with a beat on either channel restarts the count
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stuck = 0;
      else stuck++;
    end
    $error("no beat on either channel for %0d cycles", STUCK_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    logic act;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    action_i   <= ACT_INSERT;
    key_in_i   <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: dump of the empty store, flag still clear
    send_beat(ACT_DUMP, MAX_KEY);
    // extremes of the key and the signs around zero, then walk them in order
    send_beat(ACT_INSERT, '0);
    send_beat(ACT_INSERT, MAX_KEY);
    send_beat(ACT_INSERT, MIN_KEY);
    send_beat(ACT_INSERT, '1);
    send_beat(ACT_INSERT, 32'd1);
    send_beat(ACT_DUMP, '0);
    // equal keys sit side by side
    send_beat(ACT_INSERT, 32'd5);
    send_beat(ACT_INSERT, 32'd5);
    send_beat(ACT_DUMP, '1);
    // fill the store up to DEPTH keys, the maximum key stays on top
    for (int i = 0; i < DEPTH - 7; i++) send_beat(ACT_INSERT, 32'(i * 1000 - 3000));
    // full store: a key equal to the largest is dropped itself
    send_beat(ACT_INSERT, MAX_KEY);
    // full store: a small key pushes the largest one off the top
    send_beat(ACT_INSERT, -32'sd7);
    send_beat(ACT_DUMP, MIN_KEY);

    // random part: mostly inserts, with dumps of the full store mixed in
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - CALM_ITEMS) calm <= 1'b1;
      if (i == STALL_AT) stall_req <= 1'b1;
      // a run of dumps during the long hold-off keeps offering beats to a stalled block
      if (i >= STALL_AT && i < STALL_AT + 3) act = ACT_DUMP;
      else act = ($urandom_range(0, 4) == 0) ? ACT_DUMP : ACT_INSERT;
      send_beat(act, pick_key());
    end
    in_valid_i <= 1'b0;

    // drain: wait for every expected beat, then give stray beats a chance to show
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d inserts and %0d dumps, %0d result beats checked",
             n_inserts, n_dumps, beats_checked);
    $display("including an empty-store dump, duplicates, overflow and a long output stall");
    if (fails == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (pending != 0) $error("%0d expected result beats never arrived", pending);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
hdl/silu_pkg.sv
hdl/silu_cell.sv
hdl/sorted_insertion_list_unit.sv
tb/silu_checker.sv
tb/testbench.sv
